>>> rtl/lsra_pkg.sv
`default_nettype none

package lsra_pkg;

	localparam int unsigned MAX_REGS_DEF = 16;

	localparam logic [4:0]  NUM_REGS_RST   = 5'd8;
	localparam logic [15:0] FIRST_SLOT_RST = 16'd1;
	localparam logic [15:0] SLOT_TOP       = 16'hFFFF;

	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	localparam logic REG_NUM_REGS   = 1'b0;
	localparam logic REG_FIRST_SLOT = 1'b1;

	typedef struct packed {
		logic        new_set;
		logic [15:0] interval_tag;
		logic [15:0] interval_begin;
		logic [15:0] interval_end;
	} in_item_t;

	typedef struct packed {
		logic [15:0] tag_out;
		logic        got_register;
		logic [4:0]  register_number;
		logic [15:0] self_slot;
		logic        evicted_valid;
		logic [15:0] evicted_tag;
		logic [15:0] evicted_slot;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic expire;
		logic place;
		logic restart;
	} ctl_cmd_t;

endpackage

`default_nettype wire

>>> rtl/lsra_ctrl.sv
`default_nettype none

module lsra_ctrl
	import lsra_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     interval_valid,
	output logic          interval_stall,
	output logic          result_valid,
	input  wire logic     result_stall,
	input  wire logic     cfg_wr,
	output ctl_cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_EXPIRE = 3'b010,
		ST_PLACE  = 3'b100
	} state_t;

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   cfg_wr_q;
	logic   out_free;
	logic   place_go;
	logic   accept;

	assign out_free       = !out_valid_q || !result_stall;
	assign place_go       = (state_q == ST_PLACE) && out_free;
	assign interval_stall = !((state_q == ST_IDLE) || place_go);
	assign accept         = interval_valid && !interval_stall;
	assign result_valid   = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_nxt = ST_EXPIRE;
			end
			ST_EXPIRE: begin
				state_nxt = ST_PLACE;
			end
			ST_PLACE: begin
				if (out_free) state_nxt = accept ? ST_EXPIRE : ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.load    = accept;
		cmd.expire  = (state_q == ST_EXPIRE);
		cmd.place   = place_go;
		cmd.restart = cfg_wr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			cfg_wr_q    <= 1'b0;
		end else begin
			state_q  <= state_nxt;
			cfg_wr_q <= cfg_wr;
			if (place_go) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/lsra_dp.sv
`default_nettype none

module lsra_dp
	import lsra_pkg::*;
#(
	parameter int unsigned MAX_REGS = MAX_REGS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire ctl_cmd_t    cmd,
	input  wire in_item_t    interval,
	input  wire logic [4:0]  num_regs,
	input  wire logic [15:0] first_spill_slot,
	output out_item_t        result
);

	localparam int unsigned RW    = $clog2(MAX_REGS + 1);
	localparam int unsigned CW    = RW;
	localparam int unsigned IW    = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
	localparam int unsigned K_RST = (NUM_REGS_RST > MAX_REGS) ? MAX_REGS : NUM_REGS_RST;

	in_item_t        item_q;
	out_item_t       result_q, result_nxt;

	logic [15:0]     act_tag_q [MAX_REGS];
	logic [15:0]     act_end_q [MAX_REGS];
	logic [RW-1:0]   act_reg_q [MAX_REGS];
	logic [CW-1:0]   cnt_q;
	logic [RW-1:0]   fs_q [MAX_REGS];
	logic [CW-1:0]   ftop_q;
	logic [15:0]     slot_q;

	logic [CW-1:0]   k_use;
	logic [MAX_REGS-1:0] exp_hit, ins_le;
	logic [CW-1:0]   n_exp, pos, cnt_base;
	logic [15:0]     sh_tag [MAX_REGS];
	logic [15:0]     sh_end [MAX_REGS];
	logic [RW-1:0]   sh_reg [MAX_REGS];
	logic [RW-1:0]   fs_push [MAX_REGS];
	logic [15:0]     prv_tag [MAX_REGS];
	logic [15:0]     prv_end [MAX_REGS];
	logic [RW-1:0]   prv_reg [MAX_REGS];
	logic [IW-1:0]   last_idx, top_idx;
	logic            full, evict, alloc;
	logic [RW-1:0]   new_reg;

	assign result = result_q;

	always_comb begin
		if (num_regs == 5'd0) begin
			k_use = CW'(1);
		end else if (32'(num_regs) > 32'(MAX_REGS)) begin
			k_use = CW'(MAX_REGS);
		end else begin
			k_use = CW'(num_regs);
		end
	end

	// expiry: the list is sorted by end, so the expiring entries form a prefix
	always_comb begin
		for (int i = 0; i < MAX_REGS; i++) begin
			exp_hit[i] = (CW'(i) < cnt_q) && (act_end_q[i] < item_q.interval_begin);
		end
	end

	assign n_exp = CW'($countones(exp_hit));

	always_comb begin
		logic [CW:0] src;
		for (int i = 0; i < MAX_REGS; i++) begin
			src       = (CW+1)'(i) + {1'b0, n_exp};
			sh_tag[i] = act_tag_q[i];
			sh_end[i] = act_end_q[i];
			sh_reg[i] = act_reg_q[i];
			if (src < (CW+1)'(MAX_REGS)) begin
				sh_tag[i] = act_tag_q[src[IW-1:0]];
				sh_end[i] = act_end_q[src[IW-1:0]];
				sh_reg[i] = act_reg_q[src[IW-1:0]];
			end
		end
	end

	always_comb begin
		logic [CW:0] d;
		for (int s = 0; s < MAX_REGS; s++) begin
			d          = (CW+1)'(s) - {1'b0, ftop_q};
			fs_push[s] = fs_q[s];
			if ((CW'(s) >= ftop_q) && (d < {1'b0, n_exp})) begin
				fs_push[s] = act_reg_q[d[IW-1:0]];
			end
		end
	end

	// assignment
	assign full     = (cnt_q >= k_use) || (ftop_q == '0);
	assign last_idx = IW'(cnt_q - 1'b1);
	assign top_idx  = IW'(ftop_q - 1'b1);
	assign evict    = full && (cnt_q != '0) && (act_end_q[last_idx] > item_q.interval_end);
	assign alloc    = !full;
	assign cnt_base = evict ? (cnt_q - 1'b1) : cnt_q;
	assign new_reg  = evict ? act_reg_q[last_idx] : fs_q[top_idx];

	always_comb begin
		for (int i = 0; i < MAX_REGS; i++) begin
			ins_le[i] = (CW'(i) < cnt_base) && (act_end_q[i] <= item_q.interval_end);
		end
	end

	assign pos = CW'($countones(ins_le));

	for (genvar g = 0; g < MAX_REGS; g++) begin : g_cell
		if (g == 0) begin : g_head
			assign prv_tag[g] = act_tag_q[g];
			assign prv_end[g] = act_end_q[g];
			assign prv_reg[g] = act_reg_q[g];
		end else begin : g_body
			assign prv_tag[g] = act_tag_q[g-1];
			assign prv_end[g] = act_end_q[g-1];
			assign prv_reg[g] = act_reg_q[g-1];
		end
	end

	always_comb begin
		result_nxt.tag_out         = item_q.interval_tag;
		result_nxt.got_register    = evict || alloc;
		result_nxt.register_number = (evict || alloc) ? 5'(new_reg) : 5'd0;
		result_nxt.self_slot       = (full && !evict) ? slot_q : 16'd0;
		result_nxt.evicted_valid   = evict;
		result_nxt.evicted_tag     = evict ? act_tag_q[last_idx] : 16'd0;
		result_nxt.evicted_slot    = evict ? slot_q : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			ftop_q <= CW'(K_RST);
			slot_q <= FIRST_SLOT_RST;
			for (int i = 0; i < MAX_REGS; i++) begin
				fs_q[i] <= RW'(int'(K_RST) - i);
			end
		end else if (cmd.restart || (cmd.expire && item_q.new_set)) begin
			cnt_q  <= '0;
			ftop_q <= k_use;
			slot_q <= first_spill_slot;
			for (int i = 0; i < MAX_REGS; i++) begin
				fs_q[i] <= RW'(int'(k_use) - i);
			end
		end else if (cmd.expire) begin
			cnt_q  <= cnt_q - n_exp;
			ftop_q <= ftop_q + n_exp;
			for (int i = 0; i < MAX_REGS; i++) begin
				fs_q[i] <= fs_push[i];
			end
		end else if (cmd.place) begin
			if (alloc) begin
				cnt_q  <= cnt_q + 1'b1;
				ftop_q <= ftop_q - 1'b1;
			end
			if (full && (slot_q != SLOT_TOP)) begin
				slot_q <= slot_q + 16'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= interval;
		end
		if (cmd.expire && !item_q.new_set) begin
			for (int i = 0; i < MAX_REGS; i++) begin
				act_tag_q[i] <= sh_tag[i];
				act_end_q[i] <= sh_end[i];
				act_reg_q[i] <= sh_reg[i];
			end
		end
		if (cmd.place) begin
			result_q <= result_nxt;
			if (evict || alloc) begin
				for (int i = 0; i < MAX_REGS; i++) begin
					if (CW'(i) == pos) begin
						act_tag_q[i] <= item_q.interval_tag;
						act_end_q[i] <= item_q.interval_end;
						act_reg_q[i] <= new_reg;
					end else if (CW'(i) > pos) begin
						act_tag_q[i] <= prv_tag[i];
						act_end_q[i] <= prv_end[i];
						act_reg_q[i] <= prv_reg[i];
					end
				end
			end
		end
	end

	a_regs_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(({1'b0, ftop_q} + {1'b0, cnt_q}) <= (CW+1)'(MAX_REGS)))
		else $error("free and active registers exceed the register file");

	a_expire_keeps_total: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.expire && !item_q.new_set && !cmd.restart) |=>
		(({1'b0, ftop_q} + {1'b0, cnt_q}) == $past({1'b0, ftop_q} + {1'b0, cnt_q})))
		else $error("expiry lost or duplicated a register");

	a_alloc_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.place && alloc && !cmd.restart) |=> (cnt_q == CW'($past(cnt_q) + 1'b1)))
		else $error("allocation did not grow the active list");

endmodule

`default_nettype wire

>>> rtl/linear_scan_register_assigner_top.sv
`default_nettype none

// Linear scan register assigner. Takes live intervals sorted by begin, one per
// request, and returns one result per request: the physical register taken,
// or the spill slot of the interval itself, plus any active interval evicted
// to make room. Each request has an expiry step that retires
// finished intervals onto the free stack, then an assignment step that picks
// a register and inserts the interval into the sorted active list. The next
// request is taken in the assignment step when the result register is free,
// so a new request can enter while the last one is placed. Writing either
// configuration register starts a new pass in the following cycle, as a
// request with new_set does.

module linear_scan_register_assigner_top
	import lsra_pkg::*;
#(
	parameter int unsigned MAX_REGS = MAX_REGS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	input  wire logic               interval_valid,
	output logic                    interval_stall,
	input  wire in_item_t           interval,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output out_item_t               result
);

	logic [4:0]  num_regs_q;
	logic [15:0] first_slot_q;
	logic        cfg_wr;
	ctl_cmd_t    cmd;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		case (paddr[2])
			REG_NUM_REGS:   prdata = PDATA_W'(num_regs_q);
			REG_FIRST_SLOT: prdata = PDATA_W'(first_slot_q);
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_regs_q   <= NUM_REGS_RST;
			first_slot_q <= FIRST_SLOT_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_NUM_REGS:   num_regs_q   <= pwdata[4:0];
				REG_FIRST_SLOT: first_slot_q <= pwdata[15:0];
				default:        ;
			endcase
		end
	end

	lsra_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.interval_valid (interval_valid),
		.interval_stall (interval_stall),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.cfg_wr         (cfg_wr),
		.cmd            (cmd)
	);

	lsra_dp #(
		.MAX_REGS (MAX_REGS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.interval         (interval),
		.num_regs         (num_regs_q),
		.first_spill_slot (first_slot_q),
		.result           (result)
	);

endmodule

`default_nettype wire

>>> tb/linear_scan_register_assigner_top_tb.sv
`default_nettype none

module linear_scan_register_assigner_top_tb;
	import lsra_pkg::*;

	localparam int unsigned NREG = MAX_REGS_DEF;
	localparam logic [PADDR_W-1:0] ADDR_NUM_REGS   = {REG_NUM_REGS, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_FIRST_SLOT = {REG_FIRST_SLOT, 2'b00};
	localparam int HOLD_CYCLES   = 250;
	localparam int SETTLE_CYCLES = 8;

	logic               clk            = 1'b0;
	logic               arst_n         = 1'b0;
	logic               psel           = 1'b0;
	logic               penable        = 1'b0;
	logic               pwrite         = 1'b0;
	logic [PADDR_W-1:0] paddr          = '0;
	logic [PDATA_W-1:0] pwdata         = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               interval_valid = 1'b0;
	logic               interval_stall;
	in_item_t           interval       = '0;
	logic               result_valid;
	logic               result_stall   = 1'b0;
	out_item_t          result;

	linear_scan_register_assigner_top #(
		.MAX_REGS(NREG)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.interval_valid(interval_valid),
		.interval_stall(interval_stall),
		.interval      (interval),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result        (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// assigner state as the block should hold it
	logic [4:0]  cfg_num_regs;
	logic [15:0] cfg_first_slot;
	logic [15:0] live_tag [NREG];
	logic [15:0] live_end [NREG];
	logic [4:0]  live_reg [NREG];
	logic [4:0]  spare_regs [NREG];
	int unsigned live_cnt;
	int unsigned free_top;
	logic [15:0] next_slot;

	out_item_t exp_results [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_asked    = 0;
	int hold_seen     = 0;
	int hold_left     = 0;

	int sent       = 0;
	int checked    = 0;
	int mismatches = 0;
	int evictions  = 0;
	int spills     = 0;
	int settings   = 0;

	function automatic int unsigned regs_in_use();
		int unsigned k;
		k = 32'(cfg_num_regs);
		if (k < 1) k = 1;
		if (k > NREG) k = NREG;
		return k;
	endfunction

	task automatic restart_pass();
		int unsigned k;
		k = regs_in_use();
		live_cnt = 0;
		for (int i = 0; i < NREG; i++) spare_regs[i] = (i < k) ? 5'(k - i) : 5'd0;
		free_top = k;
		next_slot = cfg_first_slot;
	endtask

	function automatic logic [15:0] grab_slot();
		logic [15:0] s;
		s = next_slot;
		if (next_slot != SLOT_TOP) next_slot++;
		return s;
	endfunction

	task automatic track_interval(input logic [15:0] tag, input logic [15:0] e,
			input logic [4:0] r);
		int unsigned pos;
		if (live_cnt >= NREG) return;
		pos = live_cnt;
		while (pos > 0 && live_end[pos-1] > e) begin
			live_tag[pos] = live_tag[pos-1];
			live_end[pos] = live_end[pos-1];
			live_reg[pos] = live_reg[pos-1];
			pos--;
		end
		live_tag[pos] = tag;
		live_end[pos] = e;
		live_reg[pos] = r;
		live_cnt++;
	endtask

	task automatic assign_interval(input in_item_t it);
		out_item_t r;
		int unsigned k;
		int unsigned n;
		logic [4:0] vreg;
		if (it.new_set) restart_pass();
		k = regs_in_use();
		n = 0;
		while (n < live_cnt && live_end[n] < it.interval_begin) begin
			if (free_top < NREG) begin
				spare_regs[free_top] = live_reg[n];
				free_top++;
			end
			n++;
		end
		for (int i = n; i < live_cnt; i++) begin
			live_tag[i-n] = live_tag[i];
			live_end[i-n] = live_end[i];
			live_reg[i-n] = live_reg[i];
		end
		live_cnt -= n;
		r = '0;
		r.tag_out = it.interval_tag;
		if (live_cnt >= k || free_top == 0) begin
			if (live_cnt > 0 && live_end[live_cnt-1] > it.interval_end) begin
				live_cnt--;
				vreg = live_reg[live_cnt];
				r.evicted_valid = 1'b1;
				r.evicted_tag = live_tag[live_cnt];
				r.evicted_slot = grab_slot();
				r.got_register = 1'b1;
				r.register_number = vreg;
				track_interval(it.interval_tag, it.interval_end, vreg);
				evictions++;
			end else begin
				r.self_slot = grab_slot();
				spills++;
			end
		end else begin
			free_top--;
			r.got_register = 1'b1;
			r.register_number = spare_regs[free_top];
			track_interval(it.interval_tag, it.interval_end, spare_regs[free_top]);
		end
		exp_results.insert(exp_results.size(), r);
	endtask

	task automatic note_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= 10) $display("mismatch %s: expected %0h, got %0h", what, want, got);
	endtask

	always @(posedge clk) begin : check_results
		out_item_t want;
		if (result_valid === 1'b1 && result_stall === 1'b0) begin
			if (exp_results.size() == 0) begin
				note_mismatch("result with none pending, tag_out", 32'h0,
					32'(result.tag_out));
			end else begin
				want = exp_results.pop_front();
				checked++;
				if (result.tag_out !== want.tag_out)
					note_mismatch("tag_out", 32'(want.tag_out), 32'(result.tag_out));
				if (result.got_register !== want.got_register)
					note_mismatch("got_register", 32'(want.got_register),
						32'(result.got_register));
				if (result.register_number !== want.register_number)
					note_mismatch("register_number", 32'(want.register_number),
						32'(result.register_number));
				if (result.self_slot !== want.self_slot)
					note_mismatch("self_slot", 32'(want.self_slot), 32'(result.self_slot));
				if (result.evicted_valid !== want.evicted_valid)
					note_mismatch("evicted_valid", 32'(want.evicted_valid),
						32'(result.evicted_valid));
				if (result.evicted_tag !== want.evicted_tag)
					note_mismatch("evicted_tag", 32'(want.evicted_tag),
						32'(result.evicted_tag));
				if (result.evicted_slot !== want.evicted_slot)
					note_mismatch("evicted_slot", 32'(want.evicted_slot),
						32'(result.evicted_slot));
			end
		end
	end

	// hold off the result side for a long stretch on request, else stall at random
	always @(posedge clk) begin
		if (hold_seen != hold_asked) begin
			hold_seen <= hold_asked;
			hold_left <= HOLD_CYCLES;
			result_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	task automatic send_interval(input in_item_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			interval_valid <= 1'b0;
			@(posedge clk);
		end
		interval_valid <= 1'b1;
		interval <= it;
		do @(posedge clk); while (interval_stall !== 1'b0);
		assign_interval(it);
		sent++;
	endtask

	task automatic wait_drained();
		interval_valid <= 1'b0;
		while (exp_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
			input logic [PDATA_W-1:0] data, output logic [PDATA_W-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		logic [PDATA_W-1:0] unused;
		apb_access(1'b1, addr, data, unused);
		if (addr == ADDR_NUM_REGS) cfg_num_regs = data[4:0];
		else cfg_first_slot = data[15:0];
		restart_pass();
	endtask

	task automatic cfg_check(input logic [PADDR_W-1:0] addr);
		logic [PDATA_W-1:0] rdata;
		logic [PDATA_W-1:0] want;
		apb_access(1'b0, addr, '0, rdata);
		want = (addr == ADDR_NUM_REGS) ? {27'b0, cfg_num_regs} : {16'b0, cfg_first_slot};
		if (rdata !== want) note_mismatch("register read", want, rdata);
	endtask

	task automatic set_config(input logic [4:0] num, input logic [15:0] first);
		cfg_write(ADDR_NUM_REGS, ($urandom & ~32'h1F) | 32'(num));
		cfg_check(ADDR_NUM_REGS);
		cfg_write(ADDR_FIRST_SLOT, ($urandom & ~32'hFFFF) | 32'(first));
		cfg_check(ADDR_FIRST_SLOT);
		settings++;
	endtask

	function automatic in_item_t make_item(input logic ns, input logic [15:0] tag,
			input logic [15:0] b, input logic [15:0] e);
		in_item_t it;
		it.new_set = ns;
		it.interval_tag = tag;
		it.interval_begin = b;
		it.interval_end = e;
		return it;
	endfunction

	// mostly sorted sets of overlapping intervals, with some raw noise mixed in
	task automatic run_sequences(input int count);
		int left;
		int len;
		int cur;
		in_item_t it;
		left = count;
		while (left > 0) begin
			len = $urandom_range(3, 40);
			cur = $urandom_range(0, 65535);
			for (int j = 0; j < len && left > 0; j++) begin
				if ($urandom_range(0, 9) == 0) begin
					it = make_item(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
				end else begin
					cur = cur + $urandom_range(0, 5);
					it = make_item((j == 0) && ($urandom_range(0, 3) != 0), 16'($urandom),
						16'(cur), 16'(cur + $urandom_range(0, 48)));
				end
				send_interval(it);
				left--;
			end
		end
	endtask

	task automatic test_reset_values();
		cfg_num_regs = NUM_REGS_RST;
		cfg_first_slot = FIRST_SLOT_RST;
		restart_pass();
		cfg_check(ADDR_NUM_REGS);
		cfg_check(ADDR_FIRST_SLOT);
		for (int i = 0; i < 9; i++)
			send_interval(make_item(i == 0, 16'(100 + i), 16'(i), 16'(500 - 10 * i)));
		wait_drained();
	endtask

	task automatic test_directed();
		set_config(5'd2, 16'hFFFE);
		send_interval(make_item(1'b1, 16'h0000, 16'd0, 16'd100));
		send_interval(make_item(1'b0, 16'hFFFF, 16'd1, 16'd50));
		send_interval(make_item(1'b0, 16'h0005, 16'd2, 16'd200));
		send_interval(make_item(1'b0, 16'h0006, 16'd3, 16'd10));
		send_interval(make_item(1'b0, 16'h0007, 16'd4, 16'd50));
		send_interval(make_item(1'b0, 16'h0008, 16'd60, 16'd60));
		send_interval(make_item(1'b0, 16'h0009, 16'd70, 16'd20));
		send_interval(make_item(1'b0, 16'h000A, 16'd5, 16'd30));
		send_interval(make_item(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		send_interval(make_item(1'b1, 16'h0000, 16'h0000, 16'h0000));
		wait_drained();
		set_config(5'd0, 16'h0000);
		send_interval(make_item(1'b1, 16'h1234, 16'd0, 16'd10));
		send_interval(make_item(1'b0, 16'h4321, 16'd1, 16'd20));
		send_interval(make_item(1'b0, 16'h8000, 16'd2, 16'd5));
		wait_drained();
		set_config(5'd31, 16'hFFFF);
		send_interval(make_item(1'b1, 16'hAAAA, 16'h8000, 16'hFFFF));
		send_interval(make_item(1'b0, 16'h5555, 16'h8001, 16'h8001));
		send_interval(make_item(1'b1, 16'h00FF, 16'h7FFF, 16'h7FFF));
		wait_drained();
	endtask

	task automatic test_random_phase(input int send_pct, input int recv_pct, input int items);
		logic [4:0]  num;
		logic [15:0] first;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int chunk = 0; chunk < 4; chunk++) begin
			case (chunk)
				0: num = 5'd1;
				1: num = 5'd16;
				default: begin
					case ($urandom_range(0, 2))
						0: num = 5'($urandom_range(0, 31));
						default: num = 5'($urandom_range(2, 5));
					endcase
				end
			endcase
			case ($urandom_range(0, 3))
				0: first = 16'h0000;
				1: first = 16'hFFFF - 16'($urandom_range(0, 40));
				2: first = 16'hFFFF;
				default: first = 16'($urandom);
			endcase
			wait_drained();
			set_config(num, first);
			run_sequences(items / 4);
		end
		wait_drained();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_config(5'd4, 16'd100);
		hold_asked <= hold_asked + 1;
		run_sequences(40);
		wait_drained();
		run_sequences(20);
		wait_drained();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_directed();
		test_random_phase(10, 85, 600);
		test_random_phase(85, 10, 600);
		test_random_phase(0, 0, 600);
		test_backpressure();
		$display("ran %0d intervals under %0d register settings: %0d evictions, %0d spills",
			sent, settings, evictions, spills);
		$display("%0d results compared, %0d mismatches", checked, mismatches);
		if (mismatches == 0 && exp_results.size() == 0) begin
			$display("linear_scan_register_assigner_top_tb: done, clean");
		end else begin
			$display("linear_scan_register_assigner_top_tb: done, errors");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("linear_scan_register_assigner_top_tb: done, errors");
		$finish;
	end

endmodule

`default_nettype wire
